// ===== rtl/hglc_pkg.sv =====
// Shared types, codes and character tables for the HTTP GET request line checker.
// No dependencies.
`default_nettype none

package hglc_pkg;

    localparam int URL_LIMIT_DEF    = 256;
    localparam int NAME_RESERVE_DEF = 64;

    localparam int ROOT_W  = 9;
    localparam int LEN_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int ODATA_W = 24;

    // register index within the APB map (byte address 4*index)
    localparam logic REG_ROOT_LEN = 1'b0;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_ACC  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_REQ  = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3f;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   path_byte;
        logic [STAT_W-1:0]   status;
        logic [LEN_W-1:0]    path_length;
    } t_result;

    // expected method characters
    function automatic t_byte get_char(input logic [1:0] pos);
        t_byte c;
        case (pos)
            2'd0:    c = 8'h47; // G
            2'd1:    c = 8'h45; // E
            2'd2:    c = 8'h54; // T
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HTTP/1.1\r\n", oldest character first
    function automatic t_byte tail_v11(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2f;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2e;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h0d;
            4'd9:    c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HTTP/2\r\n", oldest character first
    function automatic t_byte tail_v2(input logic [2:0] idx);
        t_byte c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2f;
            3'd5:    c = 8'h32;
            3'd6:    c = 8'h0d;
            3'd7:    c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hglc_cfg.sv =====
// APB register block holding the server root length.
// Depends on hglc_pkg.
`default_nettype none

module hglc_cfg
    import hglc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [ROOT_W-1:0] o_root_len
);

    logic [ROOT_W-1:0] r_root_len;
    logic              sel_root;

    assign sel_root = (paddr[2] == REG_ROOT_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_len <= '0;
        end else if (psel && penable && pwrite && sel_root) begin
            r_root_len <= pwdata[ROOT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_root) begin
            prdata = APB_DW'(r_root_len);
        end
    end

    assign pready     = 1'b1;
    assign o_root_len = r_root_len;

endmodule

`default_nettype wire

// ===== rtl/hglc_parse.sv =====
// Per-byte request line state and verdict logic.
// Depends on hglc_pkg.
`default_nettype none

module hglc_parse
    import hglc_pkg::*;
#(
    parameter int URL_LIMIT    = URL_LIMIT_DEF,
    parameter int NAME_RESERVE = NAME_RESERVE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    input  wire logic [ROOT_W-1:0] i_root_len,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam int CW   = $clog2(URL_LIMIT + 1);
    localparam int SW   = ((CW > ROOT_W) ? CW : ROOT_W) + 1;
    localparam int LIM2 = URL_LIMIT - NAME_RESERVE - 1;
    localparam bit          LIM2_ALL = (LIM2 <= 0);
    localparam logic [SW-1:0] LIM2_U = (LIM2 <= 0) ? '0 : SW'(LIM2);

    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_PATH   = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    logic [1:0]    r_phase,     n_phase;
    logic          r_method_ok, n_method_ok;
    logic [1:0]    r_pos,       n_pos;
    logic [CW-1:0] r_count,     n_count;
    logic          r_slash,     n_slash;
    logic          r_dot,       n_dot;
    t_byte         r_pwin [3],  n_pwin [3];
    t_byte         r_twin [10], n_twin [10];

    logic          emit;
    logic          tail_a, tail_b;
    logic [SW-1:0] sum;
    logic [LEN_W-1:0] shown;
    logic [STAT_W-1:0] status;

    always_comb begin
        n_phase     = r_phase;
        n_method_ok = r_method_ok;
        n_pos       = r_pos;
        n_count     = r_count;
        n_slash     = r_slash;
        n_dot       = r_dot;
        n_pwin      = r_pwin;
        emit        = 1'b0;

        if (r_pos != 2'd3) begin
            if (i_byte != get_char(r_pos)) begin
                n_method_ok = 1'b0;
            end
            n_pos = r_pos + 2'd1;
        end

        for (int i = 0; i < 9; i++) begin
            n_twin[i] = r_twin[i+1];
        end
        n_twin[9] = i_byte;

        case (r_phase)
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    n_phase = PH_PATH;
                end
            end
            PH_PATH: begin
                if (i_byte == CH_QMARK || i_byte == CH_SPACE) begin
                    n_phase = PH_AFTER;
                end else begin
                    if (r_count == '0 && i_byte == CH_SLASH) begin
                        n_slash = 1'b1;
                    end
                    if (r_pwin[1] == CH_SLASH && r_pwin[2] == CH_DOT &&
                        i_byte == CH_SLASH) begin
                        n_dot = 1'b1;
                    end
                    if (r_pwin[0] == CH_SLASH && r_pwin[1] == CH_DOT &&
                        r_pwin[2] == CH_DOT && i_byte == CH_SLASH) begin
                        n_dot = 1'b1;
                    end
                    n_pwin[0] = r_pwin[1];
                    n_pwin[1] = r_pwin[2];
                    n_pwin[2] = i_byte;
                    if (r_count < CW'(URL_LIMIT)) begin
                        n_count = r_count + CW'(1);
                    end
                    emit = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // trailer match on the window as it stands after this byte
    always_comb begin
        tail_a = 1'b1;
        tail_b = 1'b1;
        for (int i = 0; i < 10; i++) begin
            if (n_twin[i] != tail_v11(4'(i))) tail_a = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            if (n_twin[i+2] != tail_v2(3'(i))) tail_b = 1'b0;
        end
    end

    assign sum   = SW'(n_count) + SW'(i_root_len);
    assign shown = (32'(n_count) > 32'd511) ? 9'd511 : LEN_W'(n_count);

    // first failing check wins
    always_comb begin
        if (!n_method_ok || n_pos != 2'd3) begin
            status = ST_NOT_ACC;
        end else if (!(tail_a || tail_b)) begin
            status = ST_BAD_REQ;
        end else if (n_phase != PH_AFTER) begin
            status = ST_BAD_REQ;
        end else if (32'(n_count) >= 32'(URL_LIMIT - 1)) begin
            status = ST_TOO_LONG;
        end else if (!n_slash) begin
            status = ST_BAD_REQ;
        end else if (n_dot) begin
            status = ST_NOT_ACC;
        end else if (LIM2_ALL || sum >= LIM2_U) begin
            status = ST_TOO_LONG;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_res_valid = i_push && (i_last || emit);
        o_res.path_length = shown;
        if (i_last) begin
            o_res.kind      = KIND_VERDICT;
            o_res.path_byte = '0;
            o_res.status    = status;
        end else begin
            o_res.kind      = KIND_PATH;
            o_res.path_byte = i_byte;
            o_res.status    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_push && i_last)) begin
            r_phase     <= PH_METHOD;
            r_method_ok <= 1'b1;
            r_pos       <= '0;
            r_count     <= '0;
            r_slash     <= 1'b0;
            r_dot       <= 1'b0;
            for (int i = 0; i < 3; i++) r_pwin[i] <= '0;
            for (int i = 0; i < 10; i++) r_twin[i] <= '0;
        end else if (i_push) begin
            r_phase     <= n_phase;
            r_method_ok <= n_method_ok;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_slash     <= n_slash;
            r_dot       <= n_dot;
            r_pwin      <= n_pwin;
            r_twin      <= n_twin;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hglc_obuf.sv =====
// Two-entry output register with skid stage for result words.
// Depends on hglc_pkg.
`default_nettype none

module hglc_obuf
    import hglc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_ov && i_ready;
    assign o_space = !r_sv;
    assign o_valid = r_ov;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (pop) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    // payload: move skid forward on pop, else land new word where there is room
    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_ov || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/http_get_request_line_check.sv =====
// HTTP GET request line checker, top level: one line byte per word in, path bytes and
// a final verdict word out. A result word is registered in the output register, or in the
// skid entry while that register is full and not taken. Throughput: one byte per cycle;
// s_axis_tready drops only while the skid entry holds a word; a take on m_axis empties it.
// Reset: synchronous, active low; clears the line state, the output buffer and root_len.
// Depends on hglc_pkg, hglc_cfg, hglc_parse, hglc_obuf.
`default_nettype none

module http_get_request_line_check
    import hglc_pkg::*;
#(
    parameter int URL_LIMIT    = URL_LIMIT_DEF,
    parameter int NAME_RESERVE = NAME_RESERVE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // line bytes in
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] line_byte
    input  wire logic               s_axis_tlast,   // last byte of the request line

    // result words out
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [ODATA_W-1:0] m_axis_tdata,   // [7:0] path_byte, [9:8] status,
                                                    // [18:10] path_length, [23:19] zero
    output logic                    m_axis_tuser,   // [0] kind: 0 path byte, 1 verdict

    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    logic [ROOT_W-1:0] root_len;
    logic              push;
    logic              space;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    // a byte is taken whenever the skid entry is free
    assign s_axis_tready = space;
    assign push          = s_axis_tvalid && space;

    hglc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_root_len (root_len)
    );

    // line state: method prefix, path tracking, trailer window, verdict chain
    hglc_parse #(
        .URL_LIMIT    (URL_LIMIT),
        .NAME_RESERVE (NAME_RESERVE)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_root_len  (root_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold result words until the master side takes them
    hglc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'd0, out_res.path_length, out_res.status, out_res.path_byte};

endmodule

`default_nettype wire
